// ===== rtl/rlcs_pkg.sv =====
// Shared types and constants of the RGB LED chain serializer.
`default_nettype none
package rlcs_pkg;

  localparam int WORD_W     = 24;
  localparam int COLOR_W    = 8;
  localparam int INDEX_W    = 3;
  localparam int COUNT_W    = 4;
  localparam int TICK_W     = 10;
  localparam int LATCH_W    = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BIT_CNT_W  = 5;

  localparam logic [COUNT_W-1:0] LED_COUNT_RST   = 4'd0;
  localparam logic [TICK_W-1:0]  ZERO_HIGH_RST   = 10'd40;
  localparam logic [TICK_W-1:0]  ONE_HIGH_RST    = 10'd80;
  localparam logic [TICK_W-1:0]  BIT_PERIOD_RST  = 10'd125;
  localparam logic [LATCH_W-1:0] LATCH_TICKS_RST = 16'd7500;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_LATCH = 2'd2
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LED_COUNT  = 3'd0,
    REG_ZERO_HIGH  = 3'd1,
    REG_ONE_HIGH   = 3'd2,
    REG_BIT_PERIOD = 3'd3,
    REG_LATCH      = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_SHIFT,
    ST_PUSH,
    ST_LATCH
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] grb_word;
    logic              is_latch;
    logic              last;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/rgb_led_chain_serializer_top.sv =====
// Top level: pixel store, frame sequencer and bit-serial word shifter.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/ready    | command, pixel index, color
//   rsp     | out       | rsp_valid/ready    | GRB word, latch flag, last
//   cfg     | in        | cfg_valid/ready    | register index, data
//
// Each LED word shifts out MSB first, one bit per bit slot; a slot ends once both
// bit_period_ticks and this bit's high ticks are spent, so a word is 24 slots and
// a frame led_count words, capped at MAX_LEDS. A latch item counts in ST_LATCH
// against latch_ticks, then sends a zero word. After reset a clearing pass over
// all MAX_LEDS entries zeroes the store before req_ready rises; cfg writes are
// taken at any time. A stalled rsp holds the last word in the shifter.
`default_nettype none
module rgb_led_chain_serializer_top #(
  parameter int MAX_LEDS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  rlcs_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output rlcs_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rlcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rlcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import rlcs_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int IW = (NW > INDEX_W) ? NW : INDEX_W;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_LEDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);
  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(WORD_W - 1);

  state_t state, state_next;

  logic [COUNT_W-1:0] led_count;
  logic [TICK_W-1:0]  zero_high_ticks;
  logic [TICK_W-1:0]  one_high_ticks;
  logic [TICK_W-1:0]  bit_period_ticks;
  logic [LATCH_W-1:0] latch_ticks;

  logic [AW-1:0]        addr;
  logic                 clear_q;
  logic                 latch_q;
  logic [WORD_W-1:0]    sreg;
  logic [WORD_W-1:0]    asm_word;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [TICK_W-1:0]    tick;
  logic [LATCH_W-1:0]   lcnt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic [NW-1:0]     frame_len;
  logic [IW-1:0]     pix_ext;
  logic              pix_in_range;
  logic              last_word;
  logic [TICK_W-1:0] high_ticks;
  logic              bit_end;
  logic              latch_end;
  logic              push_go;
  logic              req_go;

  rlcs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_LEDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  // Frame length saturates at the store depth.
  assign frame_len = (NW'(led_count) > MAX_N) ? MAX_N : NW'(led_count);
  assign pix_ext = IW'(req.pixel_index);
  assign pix_in_range = pix_ext < IW'(MAX_LEDS);
  assign last_word = (NW'(addr) + NW'(1)) == frame_len;

  // A bit slot ends once both the period and this bit's high time are spent.
  assign high_ticks = sreg[WORD_W-1] ? one_high_ticks : zero_high_ticks;
  assign bit_end = (({1'b0, tick} + (TICK_W+1)'(1)) >= {1'b0, bit_period_ticks})
                   && (tick >= high_ticks);
  assign latch_end = ({1'b0, lcnt} + (LATCH_W+1)'(1)) >= {1'b0, latch_ticks};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_WIPE: begin
        if (addr == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req.command == CMD_SET || req.command == CMD_CLEAR) begin
            state_next = (frame_len == '0) ? ST_IDLE : ST_FETCH;
          end else if (req.command == CMD_LATCH) begin
            state_next = ST_LATCH;
          end
        end
      end
      ST_FETCH: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_SHIFT;
      ST_SHIFT: begin
        if (bit_end && bit_cnt == BIT_LAST) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = (latch_q || last_word) ? ST_IDLE : ST_FETCH;
        end
      end
      ST_LATCH: begin
        if (latch_end) state_next = ST_PUSH;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == ST_IDLE);
    cfg_ready = 1'b1;
    req_go    = req_valid && req_ready;
    push_go   = (state == ST_PUSH) && (!rsp_valid || rsp_ready);
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = '0;
    unique case (state)
      ST_WIPE: ram_we = 1'b1;
      ST_IDLE: begin
        if (req_go && req.command == CMD_SET && pix_in_range) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(req.pixel_index);
          ram_wdata = {req.green, req.red, req.blue};
        end
      end
      ST_LOAD: ram_we = clear_q;
      default: ram_we = 1'b0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_WIPE;
      addr             <= '0;
      rsp_valid        <= 1'b0;
      led_count        <= LED_COUNT_RST;
      zero_high_ticks  <= ZERO_HIGH_RST;
      one_high_ticks   <= ONE_HIGH_RST;
      bit_period_ticks <= BIT_PERIOD_RST;
      latch_ticks      <= LATCH_TICKS_RST;
    end else begin
      state <= state_next;
      if (state == ST_WIPE) begin
        addr <= (addr == LAST_ADDR) ? '0 : addr + AW'(1);
      end else if (req_go) begin
        addr <= '0;
      end else if (push_go) begin
        addr <= addr + AW'(1);
      end
      if (push_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_LED_COUNT:  led_count        <= cfg_data[COUNT_W-1:0];
          REG_ZERO_HIGH:  zero_high_ticks  <= cfg_data[TICK_W-1:0];
          REG_ONE_HIGH:   one_high_ticks   <= cfg_data[TICK_W-1:0];
          REG_BIT_PERIOD: bit_period_ticks <= cfg_data[TICK_W-1:0];
          REG_LATCH:      latch_ticks      <= cfg_data[LATCH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath: shifter, bit timing and output word.
  always_ff @(posedge clk) begin
    if (req_go) begin
      clear_q <= (req.command == CMD_CLEAR);
      latch_q <= (req.command == CMD_LATCH);
      lcnt    <= '0;
    end
    if (state == ST_LOAD) begin
      // A cleared entry goes out as zero.
      sreg    <= clear_q ? '0 : ram_rdata;
      bit_cnt <= '0;
      tick    <= '0;
    end else if (state == ST_SHIFT) begin
      if (bit_end) begin
        asm_word <= {asm_word[WORD_W-2:0], sreg[WORD_W-1]};
        sreg     <= {sreg[WORD_W-2:0], 1'b0};
        bit_cnt  <= bit_cnt + BIT_CNT_W'(1);
        tick     <= '0;
      end else begin
        tick <= tick + TICK_W'(1);
      end
    end
    if (state == ST_LATCH) begin
      lcnt <= lcnt + LATCH_W'(1);
    end
    if (push_go) begin
      rsp.grb_word <= latch_q ? '0 : asm_word;
      rsp.is_latch <= latch_q;
      rsp.last     <= latch_q || last_word;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rlcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rlcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== verif/tb_rgb_led_chain_serializer_top.sv =====
// Self-checking testbench of the RGB LED chain serializer: random and directed frames.
`timescale 1ns / 100ps
module tb_rgb_led_chain_serializer_top;
  import rlcs_pkg::*;

  localparam int LEDS           = 8;
  localparam int RANDOM_ITEMS   = 72;
  localparam int IDLE_GAP       = 64;
  localparam int END_GAP        = 200;
  localparam int HOLDOFF_CYCLES = 1500;
  localparam int LIMIT          = 1500000;

  localparam logic [1:0]             CMD_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE  = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_ready;
  req_t                   req = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  rsp_t                   rsp;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic         req_fire = 1'b0;
  logic         cfg_fire = 1'b0;
  logic         holdoff_armed = 1'b0;
  logic         holdoff_active = 1'b0;
  int unsigned  req_idle_pct = 0;
  int unsigned  rsp_stall_pct = 0;
  int unsigned  req_queued = 0;
  int unsigned  req_accepted = 0;
  int unsigned  mismatches = 0;

  req_t         pending_reqs[$];
  rsp_t         frame_words[$];
  logic [23:0]  led_colors[LEDS];
  logic [3:0]   chain_len = 4'd0;

  rgb_led_chain_serializer_top #(
    .MAX_LEDS(LEDS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string field, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch in %s: got %h, want %h", field, got, want);
    mismatches++;
  endtask

  // Update the pixel store copy and queue the words this item sends.
  function automatic void predict_frame(input req_t item);
    int unsigned n;
    rsp_t        w;
    n = (chain_len > LEDS) ? LEDS : chain_len;
    if (item.command == CMD_LATCH) begin
      w.grb_word = '0;
      w.is_latch = 1'b1;
      w.last     = 1'b1;
      frame_words.push_back(w);
    end else if (item.command == CMD_SET || item.command == CMD_CLEAR) begin
      if (item.command == CMD_SET) begin
        if (item.pixel_index < LEDS)
          led_colors[item.pixel_index] = {item.green, item.red, item.blue};
      end else begin
        for (int i = 0; i < n; i++) led_colors[i] = '0;
      end
      for (int i = 0; i < n; i++) begin
        w.grb_word = led_colors[i];
        w.is_latch = 1'b0;
        w.last     = (i == n - 1);
        frame_words.push_back(w);
      end
    end
  endfunction

  task automatic check_word(input rsp_t got);
    rsp_t want;
    if (frame_words.size() == 0) begin
      report_mismatch("word with none expected", got.grb_word, '0);
    end else begin
      want = frame_words.pop_front();
      if (got.grb_word !== want.grb_word)
        report_mismatch("grb_word", got.grb_word, want.grb_word);
      if (got.is_latch !== want.is_latch)
        report_mismatch("is_latch", 24'(got.is_latch), 24'(want.is_latch));
      if (got.last !== want.last)
        report_mismatch("last", 24'(got.last), 24'(want.last));
    end
  endtask

  // Sample handshakes at the rising edge; check before predicting.
  always @(posedge clk) begin
    req_fire <= !rst && req_valid && req_ready;
    cfg_fire <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (rsp_valid && rsp_ready) check_word(rsp);
      if (req_valid && req_ready) begin
        predict_frame(req);
        req_accepted++;
      end
    end
  end

  // Request driver: hold the word until taken, then maybe idle.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp_ready <= !holdoff_active && ($urandom_range(99) >= rsp_stall_pct);
  end

  // Long receiver stall so the block backs up into its input.
  initial begin : rsp_holdoff
    wait (holdoff_armed);
    @(negedge clk);
    holdoff_active <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(negedge clk);
    holdoff_active <= 1'b0;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    if (idx == REG_LED_COUNT) chain_len = data[3:0];
  endtask

  task automatic queue_item(input logic [1:0] cmd, input logic [2:0] idx,
                            input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    req_t item;
    item.command     = cmd;
    item.pixel_index = idx;
    item.red         = red;
    item.green       = green;
    item.blue        = blue;
    pending_reqs.push_back(item);
    req_queued++;
  endtask

  // Wait until every word is in and every expected result has come back.
  task automatic wait_drained();
    while (!(req_accepted == req_queued && frame_words.size() == 0)) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic write_timing(input logic [9:0] zero_hi, input logic [9:0] one_hi,
                              input logic [9:0] period, input logic [15:0] latch);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_ZERO_HIGH, {junk[5:0], zero_hi});
    write_reg(REG_ONE_HIGH, {junk[11:6], one_hi});
    write_reg(REG_BIT_PERIOD, {junk[17:12], period});
    write_reg(REG_LATCH, latch);
  endtask

  initial begin : stimulus
    int unsigned random_items;
    int unsigned pick;
    int unsigned n;
    logic [3:0]  led;
    logic [31:0] junk;
    logic [1:0]  cmd;

    random_items = 0;
    for (int i = 0; i < LEDS; i++) led_colors[i] = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: empty chain still stores the pixel; slow latch gap.
    queue_item(CMD_SET, 3'd0, 8'hFF, 8'hFF, 8'hFF);
    queue_item(CMD_LATCH, 3'd0, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_UNUSED, 3'd5, 8'h11, 8'h22, 8'h33);
    wait_drained();

    // Two LEDs at reset timing.
    write_reg(REG_LED_COUNT, 16'd2);
    queue_item(CMD_SET, 3'd1, 8'h12, 8'h34, 8'h56);
    wait_drained();

    write_reg(REG_LED_COUNT, 16'd8);
    write_timing(10'd1, 10'd2, 10'd3, 16'd5);
    queue_item(CMD_SET, 3'd7, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_SET, 3'd0, 8'hAA, 8'h55, 8'hF0);
    queue_item(CMD_SET, 3'd2, 8'h01, 8'h80, 8'h7F);
    queue_item(CMD_CLEAR, 3'd4, 8'h9C, 8'h3E, 8'h71);
    queue_item(CMD_LATCH, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    queue_item(CMD_SET, 3'd3, 8'hFF, 8'h00, 8'hFF);
    queue_item(CMD_UNUSED, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    wait_drained();

    // Counts above the chain length saturate.
    write_reg(REG_LED_COUNT, 16'hFFFF);
    queue_item(CMD_SET, 3'd6, 8'h0F, 8'hF0, 8'h3C);
    queue_item(CMD_CLEAR, 3'd0, 8'h00, 8'h00, 8'h00);
    wait_drained();
    write_reg(REG_LED_COUNT, 16'd9);
    queue_item(CMD_LATCH, 3'd2, 8'h5A, 8'hA5, 8'hC3);
    queue_item(CMD_SET, 3'd5, 8'hC3, 8'h3C, 8'h5A);
    wait_drained();

    // Longest timing on a single LED.
    write_reg(REG_LED_COUNT, 16'd1);
    write_timing(10'd1023, 10'd1023, 10'd1023, 16'hFFFF);
    queue_item(CMD_SET, 3'd0, 8'h80, 8'h01, 8'hFF);
    queue_item(CMD_LATCH, 3'd0, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Zero timing values touch only the line.
    write_reg(REG_LED_COUNT, 16'd3);
    write_timing(10'd0, 10'd0, 10'd0, 16'd0);
    write_reg(REG_SPARE, 16'hBEEF);
    queue_item(CMD_SET, 3'd2, 8'h24, 8'h42, 8'h99);
    queue_item(CMD_LATCH, 3'd1, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_CLEAR, 3'd6, 8'hE7, 8'h7E, 8'h18);
    wait_drained();

    for (int phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      junk = $urandom;
      pick = $urandom_range(99);
      if (pick < 70) led = 4'($urandom_range(8, 1));
      else if (pick < 80) led = 4'd0;
      else led = 4'($urandom_range(15, 9));
      write_reg(REG_LED_COUNT, {junk[11:0], led});
      write_timing(10'($urandom_range(3)), 10'($urandom_range(3)),
                   10'($urandom_range(4)), 16'($urandom_range(40)));

      if (phase == 4) begin
        req_idle_pct  <= 0;
        rsp_stall_pct <= 0;
        holdoff_armed <= 1'b1;
      end else begin
        case (phase % 4)
          0: begin req_idle_pct <= 0;  rsp_stall_pct <= 0;  end
          1: begin req_idle_pct <= 84; rsp_stall_pct <= 0;  end
          2: begin req_idle_pct <= 0;  rsp_stall_pct <= 84; end
          default: begin req_idle_pct <= 10; rsp_stall_pct <= 10; end
        endcase
      end

      // Two batches per phase; the sender waits for all results in between.
      for (int batch = 0; batch < 2; batch++) begin
        n = $urandom_range(8, 4);
        repeat (n) begin
          pick = $urandom_range(99);
          if (pick < 55) cmd = CMD_SET;
          else if (pick < 70) cmd = CMD_CLEAR;
          else if (pick < 92) cmd = CMD_LATCH;
          else cmd = CMD_UNUSED;
          queue_item(cmd, 3'($urandom_range(7)), 8'($urandom), 8'($urandom), 8'($urandom));
          if (cmd != CMD_UNUSED) random_items++;
        end
        wait_drained();
      end
    end

    repeat (END_GAP) @(negedge clk);
    if (mismatches == 0 && frame_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
